>>> sv/cqu_pkg.sv
`default_nettype none

package cqu_pkg;

  localparam int unsigned DEPTH_DEF = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // back-end sequencer, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_DUMP = 3'b100
  } state_e;

  // decoded command handed from front to back
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         pos;
    logic                     pos_zero;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/cqu_front.sv
`default_nettype none

module cqu_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [cqu_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [cqu_pkg::DATA_W-1:0]  data_in_i,
  input  logic [cqu_pkg::POS_W-1:0]          position_i,
  output cqu_pkg::cmd_t                      cmd_o,
  output logic                               cmd_valid_o,
  input  logic                               cmd_pop_i
);
  import cqu_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_en, pop_en;
  cmd_t       new_cmd;

  assign busy_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push_en = start_i && !busy_o;
  assign pop_en  = cmd_pop_i && cmd_valid_o;

  // classify the opcode and flag the position that can never be valid
  always_comb begin
    new_cmd.op       = op_e'(opcode_i);
    new_cmd.data     = data_in_i;
    new_cmd.pos      = position_i;
    new_cmd.pos_zero = (position_i == '0);
  end

  always_comb begin
    wr_ptr_d = push_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_en  ? ~rd_ptr_q : rd_ptr_q;
    case ({push_en, pop_en})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

>>> sv/cqu_back.sv
`default_nettype none

module cqu_back #(
  parameter int unsigned DEPTH = cqu_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cqu_pkg::cmd_t                      cmd_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_pop_o,
  output logic                               valid_o,
  output logic [cqu_pkg::ST_W-1:0]           status_o,
  output logic signed [cqu_pkg::DATA_W-1:0]  data_out_o,
  output logic                               last_o
);
  import cqu_pkg::*;

  localparam int unsigned IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam int unsigned SUMW = ((IDXW > POS_W) ? IDXW : POS_W) + 1;

  function automatic logic [IDXW-1:0] nxt(input logic [IDXW-1:0] i);
    return (i == IDXW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  state_e            state_q, state_d;
  logic [IDXW-1:0]   head_q, head_d;
  logic [IDXW-1:0]   tail_q, tail_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [IDXW-1:0]   dump_idx_q, dump_idx_d;
  logic [CNTW-1:0]   remain_q, remain_d;

  logic              wr_en, rd_en;
  logic [IDXW-1:0]   wr_addr, rd_addr;

  logic              ov_q, ov_d;
  status_e           ost_q, ost_d;
  logic [DATA_W-1:0] odata_q, odata_d;
  logic              olast_q, olast_d;

  logic              full, empty, pos_bad;
  logic [SUMW-1:0]   upd_sum;
  logic [IDXW-1:0]   upd_slot;

  assign full    = (count_q == CNTW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pos_bad = cmd_i.pos_zero || (SUMW'(cmd_i.pos) > SUMW'(count_q));
  // head + pos - 1 stays below 2*DEPTH whenever the position is valid
  assign upd_sum  = SUMW'(head_q) + SUMW'(cmd_i.pos) - SUMW'(1);
  assign upd_slot = (upd_sum >= SUMW'(DEPTH)) ? IDXW'(upd_sum - SUMW'(DEPTH))
                                              : IDXW'(upd_sum);

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    remain_d   = remain_q;
    wr_en      = 1'b0;
    wr_addr    = tail_q;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    ov_d       = 1'b0;
    ost_d      = ST_OK;
    odata_d    = cmd_i.data;
    olast_d    = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUSH: begin
              ov_d = 1'b1;
              if (full) begin
                ost_d   = ST_FULL;
                odata_d = '0;
              end else begin
                wr_en   = 1'b1;
                tail_d  = nxt(tail_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                ov_d    = 1'b1;
                ost_d   = ST_EMPTY;
                odata_d = '0;
              end else begin
                rd_en   = 1'b1;
                head_d  = nxt(head_q);
                count_d = count_q - 1'b1;
                state_d = S_POP;
              end
            end
            OP_UPDATE: begin
              ov_d = 1'b1;
              if (pos_bad) begin
                ost_d   = ST_BADPOS;
                odata_d = '0;
              end else begin
                wr_en   = 1'b1;
                wr_addr = upd_slot;
              end
            end
            OP_DUMP: begin
              if (empty) begin
                ov_d    = 1'b1;
                ost_d   = ST_EMPTY;
                odata_d = '0;
              end else begin
                rd_en      = 1'b1;
                dump_idx_d = nxt(head_q);
                remain_d   = count_q;
                state_d    = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        ov_d    = 1'b1;
        odata_d = rd_data_q;
        state_d = S_IDLE;
      end
      S_DUMP: begin
        // capture the word read last cycle before the next read replaces it
        ov_d     = 1'b1;
        odata_d  = rd_data_q;
        olast_d  = (remain_q == CNTW'(1));
        remain_d = remain_q - 1'b1;
        if (remain_q == CNTW'(1)) begin
          state_d = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = dump_idx_q;
          dump_idx_d = nxt(dump_idx_q);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      dump_idx_q <= '0;
      remain_q   <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
      remain_q   <= remain_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ost_q   <= ost_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign valid_o    = ov_q;
  assign status_o   = ost_q;
  assign data_out_o = odata_q;
  assign last_o     = olast_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(DEPTH))
    else $error("entry count above depth");

  a_ring_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNTW'(DEPTH)) |-> head_q == tail_q)
    else $error("head and tail disagree on an empty or full ring");

  a_dump_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DUMP |-> remain_q != '0)
    else $error("dump walk with no entries left");

  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> state_q == S_IDLE && valid_o && last_o)
    else $error("pop did not finish with a single last item");

endmodule

`default_nettype wire

>>> sv/circular_queue_with_update.sv
`default_nettype none

// Circular FIFO of signed 32-bit words with push, pop, in-place update and dump.
//
// Command channel: drive opcode_i, data_in_i and position_i with start_i; the item
// is taken at a rising edge where start_i is high and busy_o is low. A two-entry
// command queue sits in front, so busy_o rises only when both slots hold items.
// Result channel: each result shows on status_o, data_out_o and last_o for exactly
// one cycle with valid_o high. The receiver cannot stall; results are never held.
// Every item gives at least one result and its final result carries last_o.
//
// Path of an item: it is written into a command slot, the back end decodes it, and
// its result is registered in the output stage; push, update and any error result
// take this path. A successful pop also passes the registered read port of the ring
// memory. Dump of N entries gives N results on consecutive cycles, the first one
// after the registered read of the head entry. The back end takes a new item only
// when idle; pop and dump keep it busy while they use the single memory read port.
// Reset clears head, tail and count (queue empty) and empties the command queue; the
// stored words and the contents of the command slots are not cleared.

module circular_queue_with_update #(
  parameter int unsigned DEPTH = cqu_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [cqu_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [cqu_pkg::DATA_W-1:0]  data_in_i,
  input  logic [cqu_pkg::POS_W-1:0]          position_i,
  output logic                               valid_o,
  output logic [cqu_pkg::ST_W-1:0]           status_o,
  output logic signed [cqu_pkg::DATA_W-1:0]  data_out_o,
  output logic                               last_o
);
  import cqu_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // front: take the item, decode it, hold it until the back end is free
  cqu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .opcode_i    (opcode_i),
    .data_in_i   (data_in_i),
    .position_i  (position_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // back: own the ring pointers and the word memory, emit results
  cqu_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .data_out_o  (data_out_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
